/* rtl/ilha_pkg.sv */
package ilha_pkg;

    // Heap geometry, in 8-byte units
    localparam int HEAP_UNITS = 4096;
    localparam int UNIT_AW    = $clog2(HEAP_UNITS);
    localparam int SIZE_W     = UNIT_AW + 1;   // block size in units
    localparam int TOP_W      = UNIT_AW + 1;   // heap top, 0..HEAP_UNITS
    localparam int WALK_W     = UNIT_AW + 2;   // walk pointer, room past the top
    localparam int NEED_W     = 14;            // (65535 + 7) >> 3 fits
    localparam int ADDR_W     = 15;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] request_size;
        logic [14:0] block_address;
    } req_t;

    typedef struct packed {
        logic [14:0] payload_address;
        logic        status;
    } rsp_t;

endpackage

/* rtl/implicit_list_heap_allocator_top.sv */
// Channel  Signals                         Direction  Accepted when
// req      req_valid, req_ready, req       in         req_valid && req_ready
// rsp      rsp_valid, rsp_ready, rsp       out        rsp_valid && rsp_ready
//
// One request at a time; the header memory has one port, read data registered.
// Allocate: a header fetch and a judge per block walked, then placement: none on an
// exact fit, a remainder header write on a split, the append state on an append or a failed append.
// Free: fetch and judge the freed header, then fetch the following header and judge
// it if one exists, merging each following free block; an address outside the heap answers straight from idle.
// Reset clears the sequencer, heap top and result valid flag; the header memory
// needs no clearing, since every header read was written before.
// A result not yet taken holds the block; req_ready returns once it drains.
module implicit_list_heap_allocator_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ilha_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ilha_pkg::rsp_t rsp
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ARD  = 9'b000000010,
        S_AEV  = 9'b000000100,
        S_ASPL = 9'b000001000,
        S_AAPP = 9'b000010000,
        S_FRD  = 9'b000100000,
        S_FEV  = 9'b001000000,
        S_FNRD = 9'b010000000,
        S_FNEV = 9'b100000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [ilha_pkg::WALK_W-1:0]      u_reg, u_next;
    logic [ilha_pkg::NEED_W-1:0]      need_reg, need_next;
    logic [ilha_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [ilha_pkg::UNIT_AW-1:0]     hidx_reg, hidx_next;
    logic [ilha_pkg::TOP_W-1:0]       top_reg, top_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    ilha_pkg::rsp_t                   rsp_reg, rsp_next;

    // Header memory
    ilha_pkg::hdr_t                   hdr_mem [ilha_pkg::HEAP_UNITS];
    ilha_pkg::hdr_t                   rd_q;
    ilha_pkg::hdr_t                   mem_wdata;
    logic [ilha_pkg::UNIT_AW-1:0]     mem_addr;
    logic                             mem_we;
    logic                             mem_re;

    logic                             accept;
    logic [ilha_pkg::UNIT_AW-1:0]     slot;
    logic [ilha_pkg::UNIT_AW-1:0]     hdr_of_slot;
    logic [ilha_pkg::ADDR_W-1:0]      sum15;
    logic [ilha_pkg::ADDR_W-1:0]      s_ext;
    logic [ilha_pkg::ADDR_W-1:0]      need_ext;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign slot        = req.block_address[ilha_pkg::ADDR_W-1:3];
    assign hdr_of_slot = slot - 1'b1;
    assign s_ext       = ilha_pkg::ADDR_W'(rd_q.size);
    assign need_ext    = ilha_pkg::ADDR_W'(need_reg);

    // Payload byte address of the block whose header sits at unit
    function automatic logic [ilha_pkg::ADDR_W-1:0] pay_addr(
        input logic [ilha_pkg::UNIT_AW-1:0] unit
    );
        logic [ilha_pkg::ADDR_W-1:0] p;
        begin
            p = ilha_pkg::ADDR_W'(unit) + 1'b1;
            return p << 3;
        end
    endfunction

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        u_next         = u_reg;
        need_next      = need_reg;
        size_next      = size_reg;
        hidx_next      = hidx_reg;
        top_next       = top_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = u_reg[ilha_pkg::UNIT_AW-1:0];
        mem_wdata      = rd_q;
        sum15          = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == ilha_pkg::OP_ALLOC)
                    begin
                        need_next  = ilha_pkg::NEED_W'(({1'b0, req.request_size} + 17'd7) >> 3);
                        u_next     = '0;
                        state_next = S_ARD;
                    end
                    else if (slot != '0 &&
                             ilha_pkg::TOP_W'(hdr_of_slot) < top_reg)
                    begin
                        hidx_next  = hdr_of_slot;
                        state_next = S_FRD;
                    end
                    else
                    begin
                        // Out-of-heap free: nothing to do
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{payload_address: '0, status: ilha_pkg::ST_OK};
                    end
                end
            end

            // Allocate: fetch header at the walk pointer
            S_ARD:
            begin
                if (u_reg < ilha_pkg::WALK_W'(top_reg) &&
                    u_reg < ilha_pkg::WALK_W'(ilha_pkg::HEAP_UNITS))
                begin
                    mem_re     = 1'b1;
                    state_next = S_AEV;
                end
                else
                begin
                    state_next = S_AAPP;
                end
            end

            // Allocate: judge the fetched block
            S_AEV:
            begin
                sum15 = need_ext + 15'd2;
                if (!rd_q.used && s_ext == need_ext)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = '{used: 1'b1, size: rd_q.size};
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{payload_address: pay_addr(u_reg[ilha_pkg::UNIT_AW-1:0]),
                                       status: ilha_pkg::ST_OK};
                    state_next     = S_IDLE;
                end
                else if (!rd_q.used && s_ext >= sum15)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{used: 1'b1, size: need_reg[ilha_pkg::SIZE_W-1:0]};
                    size_next  = rd_q.size;
                    state_next = S_ASPL;
                end
                else if (rd_q.size >= ilha_pkg::SIZE_W'(ilha_pkg::HEAP_UNITS))
                begin
                    state_next = S_AAPP;
                end
                else
                begin
                    u_next     = u_reg + ilha_pkg::WALK_W'(rd_q.size) + 1'b1;
                    state_next = S_ARD;
                end
            end

            // Allocate: write the remainder header after a split
            S_ASPL:
            begin
                sum15     = ilha_pkg::ADDR_W'(u_reg) + need_ext + 1'b1;
                mem_addr  = sum15[ilha_pkg::UNIT_AW-1:0];
                mem_we    = sum15 < ilha_pkg::ADDR_W'(ilha_pkg::HEAP_UNITS);
                mem_wdata = '{used: 1'b0,
                              size: size_reg - need_reg[ilha_pkg::SIZE_W-1:0] - 1'b1};
                rsp_valid_next = 1'b1;
                rsp_next       = '{payload_address: pay_addr(u_reg[ilha_pkg::UNIT_AW-1:0]),
                                   status: ilha_pkg::ST_OK};
                state_next     = S_IDLE;
            end

            // Allocate: append at heap top or fail
            S_AAPP:
            begin
                sum15 = ilha_pkg::ADDR_W'(top_reg) + need_ext + 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
                if (sum15 > ilha_pkg::ADDR_W'(ilha_pkg::HEAP_UNITS))
                begin
                    rsp_next = '{payload_address: '0, status: ilha_pkg::ST_FULL};
                end
                else
                begin
                    mem_addr  = top_reg[ilha_pkg::UNIT_AW-1:0];
                    mem_we    = 1'b1;
                    mem_wdata = '{used: 1'b1, size: need_reg[ilha_pkg::SIZE_W-1:0]};
                    top_next  = sum15[ilha_pkg::TOP_W-1:0];
                    rsp_next  = '{payload_address: pay_addr(top_reg[ilha_pkg::UNIT_AW-1:0]),
                                  status: ilha_pkg::ST_OK};
                end
            end

            // Free: fetch the freed block's header
            S_FRD:
            begin
                mem_addr   = hidx_reg;
                mem_re     = 1'b1;
                state_next = S_FEV;
            end

            S_FEV:
            begin
                size_next = rd_q.size;
                if (rd_q.size >= ilha_pkg::SIZE_W'(ilha_pkg::HEAP_UNITS))
                begin
                    mem_addr       = hidx_reg;
                    mem_we         = 1'b1;
                    mem_wdata      = '{used: 1'b0, size: rd_q.size};
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{payload_address: '0, status: ilha_pkg::ST_OK};
                    state_next     = S_IDLE;
                end
                else
                begin
                    u_next     = ilha_pkg::WALK_W'(hidx_reg) +
                                 ilha_pkg::WALK_W'(rd_q.size) + 1'b1;
                    state_next = S_FNRD;
                end
            end

            // Free: fetch the following header, or close out
            S_FNRD:
            begin
                if (u_reg < ilha_pkg::WALK_W'(top_reg) &&
                    u_reg < ilha_pkg::WALK_W'(ilha_pkg::HEAP_UNITS))
                begin
                    mem_re     = 1'b1;
                    state_next = S_FNEV;
                end
                else
                begin
                    mem_addr       = hidx_reg;
                    mem_we         = 1'b1;
                    mem_wdata      = '{used: 1'b0, size: size_reg};
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{payload_address: '0, status: ilha_pkg::ST_OK};
                    state_next     = S_IDLE;
                end
            end

            // Free: merge a following free block, or close out at a used one
            S_FNEV:
            begin
                if (rd_q.used ||
                    rd_q.size >= ilha_pkg::SIZE_W'(ilha_pkg::HEAP_UNITS))
                begin
                    mem_addr       = hidx_reg;
                    mem_we         = 1'b1;
                    mem_wdata      = '{used: 1'b0, size: size_reg};
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{payload_address: '0, status: ilha_pkg::ST_OK};
                    state_next     = S_IDLE;
                end
                else
                begin
                    size_next  = size_reg + rd_q.size + 1'b1;
                    u_next     = u_reg + ilha_pkg::WALK_W'(rd_q.size) + 1'b1;
                    state_next = S_FNRD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        need_reg <= need_next;
        size_reg <= size_next;
        hidx_reg <= hidx_next;
        rsp_reg  <= rsp_next;
    end

    // Header memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hdr_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= hdr_mem[mem_addr];
        end
    end

    // Checks
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= ilha_pkg::TOP_W'(ilha_pkg::HEAP_UNITS))
        else $error("heap top past end of heap");

    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("header memory read and write in one cycle");

    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !rsp_valid_reg)
        else $error("result pending while a request is in progress");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE) || rsp_valid_reg)
        else $error("accepted request neither in progress nor answered");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ilha_pkg::ST_FULL |-> rsp_reg.payload_address == '0)
        else $error("failed allocation carries an address");

endmodule
